@@ hdl/hkc_pkg.sv @@
// ----------------------------------------------------------------------------
// hkc_pkg
// Shared types and constants of the Hermite keyframe curve evaluator.
// ----------------------------------------------------------------------------
package hkc_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int IDX_W  = 6;
  localparam int VAL_W  = 32;
  localparam int SEG_W  = 6;
  localparam int STAT_W = 2;
  localparam int IN_W   = 136;
  localparam int OUT_W  = 40;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [STAT_W-1:0] RS_INSIDE = 2'd0;
  localparam logic [STAT_W-1:0] RS_BEFORE = 2'd1;
  localparam logic [STAT_W-1:0] RS_AFTER  = 2'd2;
  localparam logic [STAT_W-1:0] RS_EMPTY  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIRST, ST_LAST, ST_STEP, ST_CMP, ST_SEG0, ST_SEG1, ST_PREP,
    ST_DIV, ST_U2, ST_U3, ST_M0, ST_M1, ST_H, ST_MAC, ST_FIN
  } eval_state_t;

  typedef enum logic {
    OS_WORK, OS_OUT
  } out_state_t;

endpackage

@@ hdl/hermite_keyframe_curve_eval.sv @@
// ----------------------------------------------------------------------------
// hermite_keyframe_curve_eval
// Keyframe curve table in one synchronous memory; cubic Hermite evaluation.
// ----------------------------------------------------------------------------
// Load word: written to the point memory at acceptance.
// Evaluate word: runs through the search reads over the single memory port,
//   the serial divider (one quotient bit per cycle) and the four-step MAC.
// One word in work at a time; the next word waits until the result has left
// the result register for the output port. rst clears the control state and
// the point count; the memory is not cleared.
module hermite_keyframe_curve_eval import hkc_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // point_index[5:0], time_pos[37:6], point_value[69:38], slope_in[101:70],
  // slope_out[133:102], zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  // operation
  input  logic             s_axis_tuser,
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // curve_result[31:0], segment_start[37:32], range_status[39:38]
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int UW    = FRAC_BITS + 1;
  localparam int HW    = FRAC_BITS + 4;
  localparam int XW    = 64;
  localparam int ACC_W = HW + XW + 2;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam int MEM_W = 4 * VAL_W;

  eval_state_t state, state_next;
  out_state_t  ostate;

  logic [MEM_W-1:0] mem [MAX_POINTS];
  logic [MEM_W-1:0] rdata;
  logic [AW-1:0]    raddr;

  logic [CW-1:0]    count;
  logic signed [VAL_W-1:0] q;
  logic [AW-1:0]    lo, hi, mid, last_idx;
  logic signed [VAL_W-1:0] t0, p0, so0, t1, p1, si1;
  logic signed [VAL_W:0] dx;
  logic [VAL_W+1:0] rem;
  logic [UW-1:0]    u, u2, u3;
  logic [CNT_W-1:0] cnt;
  logic signed [XW-1:0] m0, m1;
  logic signed [HW-1:0] h00, h10, h01, h11;
  logic [1:0]       k;
  logic signed [ACC_W-1:0] acc;

  logic [VAL_W-1:0]  res_val;
  logic [AW-1:0]     res_seg;
  logic [STAT_W-1:0] res_stat;
  logic              res_set;
  logic [VAL_W-1:0]  set_val;
  logic [AW-1:0]     set_seg;
  logic [STAT_W-1:0] set_stat;

  logic [IDX_W-1:0]  in_idx;
  logic signed [VAL_W-1:0] in_time, in_val, in_sin, in_sout;
  logic              accept, idx_ok;

  logic signed [VAL_W-1:0] rd_time, rd_val, rd_sin, rd_sout;
  logic signed [VAL_W:0]   dx_c, off_c;
  logic [VAL_W+1:0]  rem2;
  logic [2*UW-1:0]   prod_uu;
  logic signed [2*VAL_W:0] prod_m;
  logic [VAL_W-1:0]  slope_sel;
  logic signed [HW-1:0] mac_h;
  logic signed [XW-1:0] mac_x;
  logic signed [HW+XW-1:0] prod_mac;
  logic signed [ACC_W-1:0] acc_sh;
  logic              fits;
  logic signed [HW-1:0] u_s, u2_s, u3_s, one_s;

  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_time = s_axis_tdata[IDX_W +: VAL_W];
  assign in_val  = s_axis_tdata[IDX_W+VAL_W +: VAL_W];
  assign in_sin  = s_axis_tdata[IDX_W+2*VAL_W +: VAL_W];
  assign in_sout = s_axis_tdata[IDX_W+3*VAL_W +: VAL_W];

  assign s_axis_tready = (state == ST_IDLE) && (ostate == OS_WORK);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign idx_ok        = (32'(in_idx) < MAX_POINTS);

  assign rd_time = rdata[0 +: VAL_W];
  assign rd_val  = rdata[VAL_W +: VAL_W];
  assign rd_sin  = rdata[2*VAL_W +: VAL_W];
  assign rd_sout = rdata[3*VAL_W +: VAL_W];

  assign last_idx = AW'(count - CW'(1));
  assign mid      = AW'(({1'b0, lo} + {1'b0, hi}) >> 1);

  assign dx_c  = {t1[VAL_W-1], t1} - {t0[VAL_W-1], t0};
  assign off_c = {q[VAL_W-1], q} - {t0[VAL_W-1], t0};
  assign rem2  = {rem[VAL_W:0], 1'b0};

  assign prod_uu   = (state == ST_U2) ? u * u : u2 * u;
  assign slope_sel = (state == ST_M0) ? so0 : si1;
  assign prod_m    = dx * $signed(slope_sel);

  assign u_s   = HW'(u);
  assign u2_s  = HW'(u2);
  assign u3_s  = HW'(u3);
  assign one_s = HW'(1) <<< FRAC_BITS;

  always_comb begin
    case (k)
      2'd0:    begin mac_h = h00; mac_x = XW'(p0); end
      2'd1:    begin mac_h = h10; mac_x = m0;      end
      2'd2:    begin mac_h = h01; mac_x = XW'(p1); end
      default: begin mac_h = h11; mac_x = m1;      end
    endcase
  end
  assign prod_mac = mac_h * mac_x;

  assign acc_sh = acc >>> FRAC_BITS;
  assign fits   = (&acc_sh[ACC_W-1:VAL_W-1]) | ~(|acc_sh[ACC_W-1:VAL_W-1]);

  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == OP_LOAD && idx_ok) begin
      mem[AW'(in_idx)] <= {in_sout, in_sin, in_val, in_time};
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    raddr      = '0;
    res_set    = 1'b0;
    set_val    = '0;
    set_seg    = '0;
    set_stat   = RS_INSIDE;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_axis_tuser == OP_EVAL) begin
          if (count == '0) begin
            res_set  = 1'b1;
            set_stat = RS_EMPTY;
          end else begin
            state_next = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (q < rd_time) begin
          res_set    = 1'b1;
          set_val    = rd_val;
          set_stat   = RS_BEFORE;
          state_next = ST_IDLE;
        end else begin
          raddr      = last_idx;
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        if (q > rd_time) begin
          res_set    = 1'b1;
          set_val    = rd_val;
          set_seg    = last_idx;
          set_stat   = RS_AFTER;
          state_next = ST_IDLE;
        end else if (count == CW'(1)) begin
          res_set    = 1'b1;
          set_val    = p0;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if ((hi - lo) > AW'(1)) begin
          raddr      = mid;
          state_next = ST_CMP;
        end else begin
          raddr      = lo;
          state_next = ST_SEG0;
        end
      end
      ST_CMP:  state_next = ST_STEP;
      ST_SEG0: begin
        raddr      = AW'({1'b0, lo} + 1'b1);
        state_next = ST_SEG1;
      end
      ST_SEG1: state_next = ST_PREP;
      ST_PREP: begin
        if (dx_c[VAL_W] || dx_c == '0) begin
          res_set    = 1'b1;
          set_val    = p0;
          set_seg    = lo;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:  if (cnt == CNT_W'(1)) state_next = ST_U2;
      ST_U2:   state_next = ST_U3;
      ST_U3:   state_next = ST_M0;
      ST_M0:   state_next = ST_M1;
      ST_M1:   state_next = ST_H;
      ST_H:    state_next = ST_MAC;
      ST_MAC:  if (k == 2'd3) state_next = ST_FIN;
      ST_FIN: begin
        res_set    = 1'b1;
        set_val    = fits ? acc_sh[VAL_W-1:0]
                          : {acc_sh[ACC_W-1], {(VAL_W-1){~acc_sh[ACC_W-1]}}};
        set_seg    = lo;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (res_set && ostate == OS_OUT) state_next = state;
    if (res_set && ostate == OS_OUT) res_set = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ostate <= OS_WORK;
    end else begin
      state <= state_next;
      if (res_set) begin
        ostate <= OS_OUT;
      end else if (ostate == OS_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        ostate <= OS_WORK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept && s_axis_tuser == OP_LOAD && idx_ok && s_axis_tlast) begin
        count <= CW'(32'(in_idx) + 1);
      end
      if (ostate == OS_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ostate == OS_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {res_stat, SEG_W'(res_seg), res_val};
    end
    if (res_set) begin
      res_val  <= set_val;
      res_seg  <= set_seg;
      res_stat <= set_stat;
    end
    if (accept) q <= in_time;
    unique case (state)
      ST_FIRST: p0 <= rd_val;
      ST_LAST: begin
        lo <= '0;
        hi <= last_idx;
      end
      ST_CMP: begin
        if (q < rd_time) hi <= mid;
        else             lo <= mid;
      end
      ST_SEG0: begin
        t0  <= rd_time;
        p0  <= rd_val;
        so0 <= rd_sout;
      end
      ST_SEG1: begin
        t1  <= rd_time;
        p1  <= rd_val;
        si1 <= rd_sin;
      end
      ST_PREP: begin
        dx  <= dx_c;
        cnt <= CNT_W'(FRAC_BITS);
        if (off_c[VAL_W]) begin
          rem <= '0;
          u   <= '0;
        end else if (off_c >= dx_c) begin
          rem <= '0;
          u   <= UW'(1);
        end else begin
          rem <= (VAL_W+2)'(off_c);
          u   <= '0;
        end
      end
      ST_DIV: begin
        cnt <= cnt - CNT_W'(1);
        if (rem2 >= (VAL_W+2)'(dx)) begin
          rem <= rem2 - (VAL_W+2)'(dx);
          u   <= {u[UW-2:0], 1'b1};
        end else begin
          rem <= rem2;
          u   <= {u[UW-2:0], 1'b0};
        end
      end
      ST_U2: u2 <= UW'(prod_uu >> FRAC_BITS);
      ST_U3: u3 <= UW'(prod_uu >> FRAC_BITS);
      ST_M0: m0 <= XW'(prod_m >>> FRAC_BITS);
      ST_M1: m1 <= XW'(prod_m >>> FRAC_BITS);
      ST_H: begin
        h00 <= (u3_s <<< 1) - (u2_s <<< 1) - u2_s + one_s;
        h10 <= u3_s - (u2_s <<< 1) + u_s;
        h01 <= (u2_s <<< 1) + u2_s - (u3_s <<< 1);
        h11 <= u3_s - u2_s;
        k   <= 2'd0;
        acc <= '0;
      end
      ST_MAC: begin
        acc <= acc + ACC_W'(prod_mac);
        k   <= k + 2'd1;
      end
      default: ;
    endcase
  end

endmodule

@@ tb/tb_hermite_keyframe_curve_eval.sv @@
// ----------------------------------------------------------------------------
// tb_hermite_keyframe_curve_eval
// Self-checking bench for the keyframe curve evaluator. Loads curves of
// random size with sorted times, evaluates at random, edge and outside
// times, and compares every result word with an in-bench Hermite predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hermite_keyframe_curve_eval import hkc_pkg::*; ();

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [SEG_W-1:0]  seg;
    logic [STAT_W-1:0] status;
  } curve_word_t;

  class curve_scoreboard;
    int signed   times[DEF_MAX_POINTS];
    int signed   values[DEF_MAX_POINTS];
    int signed   sin[DEF_MAX_POINTS];
    int signed   sout[DEF_MAX_POINTS];
    int          count;
    curve_word_t pending[$];
    int          errors;
    int          checked;

    function longint floor_sh(longint x);
      return x >>> DEF_FRAC_BITS;
    endfunction

    function longint hermite(int lo, longint q);
      longint x0, dx, off, u, u2, u3, one, h00, h10, h01, h11, m0, m1, acc;
      x0 = times[lo];
      dx = longint'(times[lo+1]) - x0;
      if (dx <= 0) return values[lo];
      off = q - x0;
      if (off < 0) off = 0;
      if (off > dx) off = dx;
      u = (off << DEF_FRAC_BITS) / dx;
      u2 = (u * u) >> DEF_FRAC_BITS;
      u3 = (u2 * u) >> DEF_FRAC_BITS;
      one = longint'(1) << DEF_FRAC_BITS;
      h00 = 2 * u3 - 3 * u2 + one;
      h10 = u3 - 2 * u2 + u;
      h01 = 3 * u2 - 2 * u3;
      h11 = u3 - u2;
      m0 = floor_sh(dx * longint'(sout[lo]));
      m1 = floor_sh(dx * longint'(sin[lo+1]));
      acc = h00 * values[lo] + h10 * m0 + h01 * values[lo+1] + h11 * m1;
      return floor_sh(acc);
    endfunction

    function void note_input(logic op, logic [IDX_W-1:0] idx, logic [31:0] t,
                             logic [31:0] v, logic [31:0] si, logic [31:0] so,
                             logic fin);
      curve_word_t w;
      longint q, val;
      int lo, hi, mid;
      if (op == OP_LOAD) begin
        times[idx] = t; values[idx] = v; sin[idx] = si; sout[idx] = so;
        if (fin) count = idx + 1;
        return;
      end
      q = longint'(int'(t));
      w.seg = '0;
      if (count == 0) begin
        val = 0; w.status = RS_EMPTY;
      end else if (q < times[0]) begin
        val = values[0]; w.status = RS_BEFORE;
      end else if (q > times[count-1]) begin
        val = values[count-1]; w.status = RS_AFTER; w.seg = SEG_W'(count - 1);
      end else if (count == 1) begin
        val = values[0]; w.status = RS_INSIDE;
      end else begin
        lo = 0; hi = count - 1;
        while (hi - lo > 1) begin
          mid = (lo + hi) / 2;
          if (q < times[mid]) hi = mid; else lo = mid;
        end
        val = hermite(lo, q); w.seg = SEG_W'(lo); w.status = RS_INSIDE;
      end
      if (val > 64'sh7FFFFFFF) val = 64'sh7FFFFFFF;
      if (val < -64'sh80000000) val = -64'sh80000000;
      w.value = val[31:0];
      pending.push_back(w);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      curve_word_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.value) begin
        $error("curve_result exp %h got %h", e.value, d[31:0]); errors++;
      end
      if (d[37:32] !== e.seg) begin
        $error("segment_start exp %0d got %0d", e.seg, d[37:32]); errors++;
      end
      if (d[39:38] !== e.status) begin
        $error("range_status exp %0d got %0d", e.status, d[39:38]); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tuser = 0, s_axis_tlast = 0;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tready, m_axis_tvalid, m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;

  curve_scoreboard sb = new();
  int sent_loads, sent_evals, gap_left, burst_left;
  int signed cur_times[DEF_MAX_POINTS];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  hermite_keyframe_curve_eval dut (.*);

  // receiver stall pattern
  int rx_phase;
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    rx_phase <= rx_phase + 1;
    if (rx_phase % 400 < 100) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // hold valid through a burst; drop it only for a gap or a drain
  task automatic send_word(logic op, logic [IDX_W-1:0] idx, logic [31:0] t,
                           logic [31:0] v, logic [31:0] si, logic [31:0] so,
                           logic fin);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap_left) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= fin;
    s_axis_tdata  <= {2'b0, so, si, v, t, idx};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, idx, t, v, si, so, fin);
    if (op == OP_LOAD) sent_loads++; else sent_evals++;
  endtask

  task automatic eval_at(logic [31:0] t);
    send_word(OP_EVAL, IDX_W'($urandom), t, $urandom, $urandom, $urandom,
              1'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_slope();
    case ($urandom_range(0, 4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  // load a sorted curve of n points; every slot that evals may read is written
  task automatic load_curve(int n, logic wide);
    int signed t;
    int step;
    t = wide ? 32'sh80000000 + $urandom_range(0, 1000) : -$urandom_range(0, 32'h40000);
    for (int i = 0; i < n; i++) begin
      cur_times[i] = t;
      send_word(OP_LOAD, IDX_W'(i), t, ($urandom_range(0, 5) == 0) ? $urandom :
                $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000,
                rnd_slope(), rnd_slope(), i == n - 1);
      step = ($urandom_range(0, 6) == 0) ? 0 :
             wide ? $urandom_range(1, 32'h7FFFFFFF / n) : $urandom_range(1, 32'h30000);
      if (longint'(t) + step <= 64'sh7FFFFFFF) t += step;
    end
  endtask

  task automatic random_evals(int n, int k);
    int i;
    int signed a;
    for (int j = 0; j < k; j++) begin
      case ($urandom_range(0, 9))
        0: eval_at($urandom);
        1: eval_at(cur_times[0] - $urandom_range(1, 100));
        2: eval_at(cur_times[n-1] + $urandom_range(0, 100));
        3: eval_at(cur_times[$urandom_range(0, n - 1)]);
        default: begin
          i = $urandom_range(0, n - 1);
          a = cur_times[i];
          if (i < n - 1) a += $urandom_range(0, cur_times[i+1] - cur_times[i]);
          eval_at(a);
        end
      endcase
    end
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty curve, extremes, single point, equal times
    eval_at(32'h80000000);
    eval_at(32'h7FFFFFFF);
    send_word(OP_LOAD, 0, 32'h00010000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1);
    eval_at(32'h00010000);
    eval_at(32'h0000FFFF);
    eval_at(32'h00010001);
    send_word(OP_LOAD, 1, 32'h00010000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
    send_word(OP_LOAD, 63, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    eval_at(32'h00010000);
    send_word(OP_LOAD, 1, 32'h00010000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1);
    eval_at(32'h00010000);
    send_word(OP_LOAD, 2, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1);
    eval_at(32'h40000000);
    eval_at(32'h7FFFFFFF);
    drain();
    load_curve(64, 1'b1);
    eval_at(32'h80000000);
    eval_at(32'h7FFFFFFF);
    random_evals(64, 10);
    drain();
    // random curves, mostly small
    while (sent_loads + sent_evals < 500) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 8);
      load_curve(n, $urandom_range(0, 3) == 0);
      random_evals(n, $urandom_range(5, 20));
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();
    $display("loads %0d, evaluates %0d, results checked %0d",
             sent_loads, sent_evals, sb.checked);
    $display("curves of 1..64 points, wide and narrow time spans, outside queries");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
